// ===== hw/rtl/ppq_pkg.sv =====
// shared types and constants of the per-port packet ring queue
// no dependencies

package ppq_pkg;

  localparam int OPCODE_W  = 2;
  localparam int PORT_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int CAP_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int HLEN_W    = 12;
  localparam int OCC_W     = 6;
  localparam int IN_USER_W  = OPCODE_W + PORT_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - BYTE_W - HLEN_W - OCC_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DROP_FULL = 3'd1,
    ST_DROP_LONG = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_SMALL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DROP_NONE = 2'd0,
    DROP_FULL = 2'd1,
    DROP_LONG = 2'd2
  } drop_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

endpackage

// ===== hw/rtl/ppq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module ppq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/per_port_packet_ring_queue.sv =====
// Per-port packet ring queue: every port owns a ring of SLOTS packet slots of up to
// MAX_LENGTH bytes each; push, pop and clear words give one result word each.
// For each item, in the accept cycle the packet store and slot length memories are
// read at the addressed port's head; in the next cycle the result is formed and the
// store, lengths and per-port pointers are written back. A result that is not taken
// holds off the next accept. No clearing pass after reset.
// Depends on ppq_pkg and ppq_ram.

module per_port_packet_ring_queue #(
  parameter int PORTS      = 4,
  parameter int SLOTS      = 32,
  parameter int MAX_LENGTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppq_pkg::IN_DATA_W-1:0]  in_tdata,   // byte_in, reader_capacity
  input  logic [ppq_pkg::IN_USER_W-1:0]  in_tuser,   // opcode, port
  input  logic                           in_tlast,   // end_of_packet
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ppq_pkg::OUT_DATA_W-1:0] out_tdata,  // byte_out, head_length, occupancy
  output logic [ppq_pkg::STATUS_W-1:0]   out_tuser,  // status
  output logic                           out_tlast   // final_byte
);

  localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int OW  = $clog2(MAX_LENGTH);
  localparam int SAW = PW + SW + OW;
  localparam int LAW = PW + SW;

  // input word fields
  ppq_pkg::opcode_t              in_op;
  logic [ppq_pkg::PORT_W-1:0]    in_port;
  logic [ppq_pkg::BYTE_W-1:0]    in_byte;
  logic [ppq_pkg::CAP_W-1:0]     in_cap;
  logic                          in_port_ok;
  logic [PW-1:0]                 in_pidx;
  logic                          accept;

  assign in_op      = ppq_pkg::opcode_t'(in_tuser[ppq_pkg::OPCODE_W-1:0]);
  assign in_port    = in_tuser[ppq_pkg::IN_USER_W-1:ppq_pkg::OPCODE_W];
  assign in_byte    = in_tdata[ppq_pkg::BYTE_W-1:0];
  assign in_cap     = in_tdata[ppq_pkg::BYTE_W+ppq_pkg::CAP_W-1:ppq_pkg::BYTE_W];
  assign in_port_ok = (32'(in_port) < PORTS);
  assign in_pidx    = in_port_ok ? PW'(in_port) : '0;
  assign accept     = in_tvalid && in_tready;

  // per-port state
  logic [SW-1:0]   head_r  [PORTS];
  logic [SW-1:0]   tail_r  [PORTS];
  logic [CW-1:0]   count_r [PORTS];
  logic [LW-1:0]   fill_r  [PORTS];
  logic [LW-1:0]   drain_r [PORTS];
  ppq_pkg::drop_t  drop_r  [PORTS];
  logic [SLOTS-1:0] valid_r [PORTS];

  // registered item
  ppq_pkg::opcode_t           op_r;
  logic [PW-1:0]              pidx_r;
  logic                       port_ok_r;
  logic [ppq_pkg::BYTE_W-1:0] byte_r;
  logic                       eop_r;
  logic [ppq_pkg::CAP_W-1:0]  cap_r;

  ppq_pkg::fsm_t state_r, state_nxt;
  logic          exec_en;
  logic          mem_re;

  // memory ports
  logic [LW-1:0]  drain_rd;
  logic [OW-1:0]  rd_off;
  logic [SAW-1:0] store_raddr;
  logic [SAW-1:0] store_waddr;
  logic           store_we;
  logic [ppq_pkg::BYTE_W-1:0] store_rdata;
  logic [LAW-1:0] len_raddr;
  logic [LAW-1:0] len_waddr;
  logic           len_we;
  logic [LW-1:0]  len_wdata;
  logic [LW-1:0]  len_rdata;

  assign drain_rd    = drain_r[in_pidx];
  assign rd_off      = (32'(drain_rd) >= MAX_LENGTH) ? OW'(MAX_LENGTH - 1) : drain_rd[OW-1:0];
  assign store_raddr = {in_pidx, head_r[in_pidx], rd_off};
  assign len_raddr   = {in_pidx, head_r[in_pidx]};

  ppq_ram #(
    .WIDTH (ppq_pkg::BYTE_W),
    .DEPTH (2 ** SAW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (byte_r),
    .re    (mem_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  ppq_ram #(
    .WIDTH (LW),
    .DEPTH (2 ** LAW)
  ) u_len (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (mem_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  // control
  always_comb begin
    unique case (state_r)
      ppq_pkg::FSM_IDLE: state_nxt = accept ? ppq_pkg::FSM_EXEC : ppq_pkg::FSM_IDLE;
      ppq_pkg::FSM_EXEC: state_nxt = ppq_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    exec_en   = 1'b0;
    unique case (state_r)
      ppq_pkg::FSM_IDLE: in_tready = !out_tvalid || out_tready;
      ppq_pkg::FSM_EXEC: exec_en   = 1'b1;
    endcase
  end

  assign mem_re = accept;

  // execute stage
  logic [SW-1:0]  cur_head, cur_tail, head_nxt, tail_nxt;
  logic [CW-1:0]  cur_count, count_nxt;
  logic [LW-1:0]  cur_fill, cur_drain, fill_nxt, drain_nxt, fill_inc, drain_inc;
  ppq_pkg::drop_t cur_drop, drop_nxt;
  logic           valid_set, valid_clr, row_clr;
  ppq_pkg::status_t status;
  logic [ppq_pkg::BYTE_W-1:0] bout;
  logic           fin;
  logic [LW-1:0]  hlen;

  assign cur_head  = head_r[pidx_r];
  assign cur_tail  = tail_r[pidx_r];
  assign cur_count = count_r[pidx_r];
  assign cur_fill  = fill_r[pidx_r];
  assign cur_drain = drain_r[pidx_r];
  assign cur_drop  = drop_r[pidx_r];
  assign fill_inc  = cur_fill + LW'(1);
  assign drain_inc = cur_drain + LW'(1);

  assign store_waddr = {pidx_r, cur_tail, cur_fill[OW-1:0]};
  assign len_waddr   = {pidx_r, cur_tail};
  assign len_wdata   = fill_inc;

  always_comb begin
    head_nxt  = cur_head;
    tail_nxt  = cur_tail;
    count_nxt = cur_count;
    fill_nxt  = cur_fill;
    drain_nxt = cur_drain;
    drop_nxt  = cur_drop;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    row_clr   = 1'b0;
    store_we  = 1'b0;
    len_we    = 1'b0;
    status    = ppq_pkg::ST_OK;
    bout      = '0;
    fin       = 1'b0;
    hlen      = '0;
    if (!port_ok_r) begin
      status = ppq_pkg::ST_EMPTY;
    end else begin
      unique case (op_r)
        ppq_pkg::OP_PUSH: begin
          if (cur_drop != ppq_pkg::DROP_NONE) begin
            status = ppq_pkg::status_t'({1'b0, cur_drop});
            if (eop_r) begin
              drop_nxt = ppq_pkg::DROP_NONE;
            end
          end else if (cur_fill == '0 && 32'(cur_count) >= SLOTS) begin
            status = ppq_pkg::ST_DROP_FULL;
            if (!eop_r) begin
              drop_nxt = ppq_pkg::DROP_FULL;
            end
          end else if (32'(cur_fill) >= MAX_LENGTH) begin
            status   = ppq_pkg::ST_DROP_LONG;
            fill_nxt = '0;
            if (!eop_r) begin
              drop_nxt = ppq_pkg::DROP_LONG;
            end
          end else begin
            store_we = exec_en;
            hlen     = fill_inc;
            fill_nxt = fill_inc;
            if (eop_r) begin
              len_we    = exec_en;
              valid_set = 1'b1;
              tail_nxt  = (32'(cur_tail) == SLOTS - 1) ? '0 : cur_tail + SW'(1);
              count_nxt = cur_count + CW'(1);
              fill_nxt  = '0;
            end
          end
        end
        ppq_pkg::OP_POP: begin
          if (cur_count == '0 || !valid_r[pidx_r][cur_head]) begin
            status = ppq_pkg::ST_EMPTY;
          end else begin
            hlen = len_rdata;
            if (cur_drain == '0 && 32'(len_rdata) > 32'(cap_r)) begin
              status = ppq_pkg::ST_SMALL;
            end else begin
              bout      = store_rdata;
              drain_nxt = drain_inc;
              if (drain_inc >= len_rdata) begin
                fin       = 1'b1;
                valid_clr = 1'b1;
                head_nxt  = (32'(cur_head) == SLOTS - 1) ? '0 : cur_head + SW'(1);
                count_nxt = cur_count - CW'(1);
                drain_nxt = '0;
              end
            end
          end
        end
        ppq_pkg::OP_CLEAR: begin
          row_clr   = 1'b1;
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          fill_nxt  = '0;
          drain_nxt = '0;
          drop_nxt  = ppq_pkg::DROP_NONE;
        end
        ppq_pkg::OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppq_pkg::FSM_IDLE;
      for (int p = 0; p < PORTS; p++) begin
        head_r[p]  <= '0;
        tail_r[p]  <= '0;
        count_r[p] <= '0;
        fill_r[p]  <= '0;
        drain_r[p] <= '0;
        drop_r[p]  <= ppq_pkg::DROP_NONE;
        valid_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (exec_en && port_ok_r) begin
        head_r[pidx_r]  <= head_nxt;
        tail_r[pidx_r]  <= tail_nxt;
        count_r[pidx_r] <= count_nxt;
        fill_r[pidx_r]  <= fill_nxt;
        drain_r[pidx_r] <= drain_nxt;
        drop_r[pidx_r]  <= drop_nxt;
        if (row_clr) begin
          valid_r[pidx_r] <= '0;
        end else if (valid_set) begin
          valid_r[pidx_r][cur_tail] <= 1'b1;
        end else if (valid_clr) begin
          valid_r[pidx_r][cur_head] <= 1'b0;
        end
      end
    end
  end

  // accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      pidx_r    <= in_pidx;
      port_ok_r <= in_port_ok;
      byte_r    <= in_byte;
      eop_r     <= in_tlast;
      cap_r     <= in_cap;
    end
  end

  // output register
  logic                          out_valid_r;
  logic [ppq_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [ppq_pkg::STATUS_W-1:0]  out_user_r;
  logic                          out_last_r;
  logic [ppq_pkg::OCC_W-1:0]     occ;

  assign occ = port_ok_r ? ppq_pkg::OCC_W'(count_nxt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      out_data_r <= {{ppq_pkg::OUT_PAD_W{1'b0}}, occ, ppq_pkg::HLEN_W'(hlen), bout};
      out_user_r <= status;
      out_last_r <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/ppq_checker.sv =====
// port-level checks for the per-port packet ring queue, bound to the top level
// depends on ppq_pkg and per_port_packet_ring_queue

module ppq_checker #(
  parameter int SLOTS = 32
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ppq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [ppq_pkg::STATUS_W-1:0]   out_tuser,
  input logic                           out_tlast
);

  localparam int OCC_LO = ppq_pkg::BYTE_W + ppq_pkg::HLEN_W;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // every accepted word is followed by the execute state, with no accept, and then by a valid result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 out_tvalid)
    else $error("accepted word gave no result");

  // a final byte only on a good pop
  a_final_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ppq_pkg::ST_OK)
    else $error("final byte with error status");

  // an empty pop carries no byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ppq_pkg::ST_EMPTY |-> out_tdata[ppq_pkg::BYTE_W-1:0] == '0
      && !out_tlast)
    else $error("empty result carries data");

  // occupancy never beyond the ring size
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[OCC_LO+ppq_pkg::OCC_W-1:OCC_LO]) <= SLOTS)
    else $error("occupancy beyond ring size");

endmodule

bind per_port_packet_ring_queue ppq_checker #(.SLOTS(SLOTS)) u_ppq_checker (.*);
